// ----- rtl/core/xfec_pkg.sv -----
// Shared types and constants for the XOR parity packet recovery block.
package xfec_pkg;

  localparam int unsigned FRAMES_DEF        = 1024;
  localparam int unsigned PAYLOAD_BYTES_DEF = 160;

  localparam int unsigned SEQ_W     = 31;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned OUT_SEQ_W = 10;

  // Fate of the packet in flight, latched on its first word.
  typedef enum logic [1:0] {
    ACT_DROP    = 2'd0,
    ACT_FORWARD = 2'd1,
    ACT_RECOVER = 2'd2
  } act_t;

endpackage

// ----- rtl/core/xfec_if.sv -----
// Valid/ready channel interfaces for input and result words.
interface xfec_in_if
  import xfec_pkg::*;
();
  logic             valid;
  logic             ready;
  logic             is_parity;
  logic [SEQ_W-1:0] seq;
  logic [BYTE_W-1:0] data_byte;
  logic             last_byte;

  modport source (output valid, is_parity, seq, data_byte, last_byte, input ready);
  modport sink   (input valid, is_parity, seq, data_byte, last_byte, output ready);
endinterface

interface xfec_out_if
  import xfec_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [OUT_SEQ_W-1:0] out_seq;
  logic [BYTE_W-1:0]    out_byte;
  logic                 out_last;
  logic                 recovered;

  modport source (output valid, out_seq, out_byte, out_last, recovered, input ready);
  modport sink   (input valid, out_seq, out_byte, out_last, recovered, output ready);
endinterface

// ----- rtl/core/xfec_held_map.sv -----
// Held-packet bitmap: dual-read memory with post-reset clearing pass and write forwarding.
module xfec_held_map
  import xfec_pkg::*;
#(
  parameter int unsigned FRAMES = FRAMES_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      rd_en,
  input  logic [$clog2(FRAMES)-1:0] rd_hi_addr,
  input  logic [$clog2(FRAMES)-1:0] rd_lo_addr,
  input  logic                      wr_en,
  input  logic [$clog2(FRAMES)-1:0] wr_addr,
  output logic                      held_hi,
  output logic                      held_lo,
  output logic                      busy
);

  localparam int unsigned FW = $clog2(FRAMES);

  logic          held_mem [FRAMES];
  logic          hi_q_r;
  logic          lo_q_r;
  logic [FW-1:0] rd_hi_r;
  logic [FW-1:0] rd_lo_r;
  logic          fwd_v_r;
  logic [FW-1:0] fwd_a_r;
  logic          clearing_r;
  logic [FW-1:0] clr_cnt_r;

  logic          mem_we;
  logic [FW-1:0] mem_wa;

  assign mem_we = clearing_r || wr_en;
  assign mem_wa = clearing_r ? clr_cnt_r : wr_addr;
  assign busy   = clearing_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      held_mem[mem_wa] <= !clearing_r;
    end
    if (rd_en) begin
      hi_q_r  <= held_mem[rd_hi_addr];
      lo_q_r  <= held_mem[rd_lo_addr];
      rd_hi_r <= rd_hi_addr;
      rd_lo_r <= rd_lo_addr;
      fwd_a_r <= wr_addr;
    end
  end

  // a write at the same edge as the read is not seen by the array
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_v_r    <= 1'b0;
      clearing_r <= 1'b1;
      clr_cnt_r  <= '0;
    end else begin
      if (rd_en) begin
        fwd_v_r <= wr_en && !clearing_r;
      end
      if (clearing_r) begin
        if (clr_cnt_r == FW'(FRAMES - 1)) begin
          clearing_r <= 1'b0;
        end else begin
          clr_cnt_r <= clr_cnt_r + FW'(1);
        end
      end
    end
  end

  assign held_hi = hi_q_r || (fwd_v_r && (fwd_a_r == rd_hi_r));
  assign held_lo = lo_q_r || (fwd_v_r && (fwd_a_r == rd_lo_r));

endmodule

// ----- rtl/core/xor_fec_packet_recovery.sv -----
// An accepted word that is kept passes the stage 1, stage 2 and stage 3 registers to the output.
// Throughput: one word per cycle once cleared; stalls only on output backpressure.
// Each word does one payload store read and one write; the held map is read on the
// first word of a packet and written once per kept packet, with forwarding.
// Reset: a held-map clearing pass over all FRAMES entries runs with in ready low.
// The payload store is not cleared.
module xor_fec_packet_recovery
  import xfec_pkg::*;
#(
  parameter int unsigned FRAMES        = FRAMES_DEF,
  parameter int unsigned PAYLOAD_BYTES = PAYLOAD_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  xfec_in_if.sink    in_word,
  xfec_out_if.source out_word
);

  localparam int unsigned FW    = $clog2(FRAMES);
  localparam int unsigned PW    = $clog2(PAYLOAD_BYTES + 1);
  localparam int unsigned DEPTH = FRAMES * PAYLOAD_BYTES;
  localparam int unsigned AW    = $clog2(DEPTH);

  logic advance;
  logic in_acc;
  logic busy;

  // input side: byte position
  logic [PW-1:0] pos_r;

  // stage 1: decision
  logic              p1_v_r;
  logic              p1_first_r;
  logic              p1_parity_r;
  logic              p1_inrange_r;
  logic              p1_nz_r;
  logic [FW-1:0]     p1_hi_r;
  logic [PW-1:0]     p1_pos_r;
  logic [BYTE_W-1:0] p1_byte_r;
  logic              p1_last_r;

  act_t          act_r;
  logic [FW-1:0] tgt_r;
  logic [FW-1:0] src_r;

  logic          held_hi;
  logic          held_lo;
  act_t          act_dec;
  logic [FW-1:0] tgt_dec;
  logic [FW-1:0] src_dec;
  act_t          act_cur;
  logic [FW-1:0] tgt_cur;
  logic [FW-1:0] src_cur;
  logic          emit1;
  logic          held_we;

  // stage 2: address
  logic              p2_v_r;
  logic [FW-1:0]     p2_tgt_r;
  logic [FW-1:0]     p2_src_r;
  logic [PW-1:0]     p2_pos_r;
  logic [BYTE_W-1:0] p2_byte_r;
  logic              p2_last_r;
  logic              p2_rec_r;
  logic [AW-1:0]     tgt_addr;
  logic [AW-1:0]     src_addr;

  // stage 3: output
  logic              p3_v_r;
  logic [AW-1:0]     p3_addr_r;
  logic [FW-1:0]     p3_seq_r;
  logic [BYTE_W-1:0] p3_byte_r;
  logic              p3_last_r;
  logic              p3_rec_r;
  logic [BYTE_W-1:0] rd_q_r;
  logic              fwd_v_r;
  logic [BYTE_W-1:0] fwd_d_r;
  logic [BYTE_W-1:0] src_byte;
  logic [BYTE_W-1:0] out_data;

  logic [BYTE_W-1:0] store_mem [DEPTH];

  assign advance       = !p3_v_r || out_word.ready;
  assign in_word.ready = advance && !busy;
  assign in_acc        = in_word.valid && in_word.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else if (in_acc) begin
      if (in_word.last_byte) begin
        pos_r <= '0;
      end else if (pos_r < PW'(PAYLOAD_BYTES)) begin
        pos_r <= pos_r + PW'(1);
      end
    end
  end

  xfec_held_map #(
    .FRAMES(FRAMES)
  ) u_held_map (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_en     (advance),
    .rd_hi_addr(in_word.seq[FW-1:0]),
    .rd_lo_addr(in_word.seq[FW-1:0] - FW'(1)),
    .wr_en     (held_we),
    .wr_addr   (tgt_dec),
    .held_hi   (held_hi),
    .held_lo   (held_lo),
    .busy      (busy)
  );

  // ---------------- stage 1 ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_v_r <= 1'b0;
    end else if (advance) begin
      p1_v_r <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      p1_first_r   <= (pos_r == '0);
      p1_parity_r  <= in_word.is_parity;
      p1_inrange_r <= (in_word.seq < SEQ_W'(FRAMES));
      p1_nz_r      <= (in_word.seq != '0);
      p1_hi_r      <= in_word.seq[FW-1:0];
      p1_pos_r     <= pos_r;
      p1_byte_r    <= in_word.data_byte;
      p1_last_r    <= in_word.last_byte;
    end
  end

  always_comb begin
    act_dec = ACT_DROP;
    tgt_dec = tgt_r;
    src_dec = src_r;
    if (!p1_parity_r) begin
      if (p1_inrange_r && !held_hi) begin
        act_dec = ACT_FORWARD;
        tgt_dec = p1_hi_r;
      end
    end else if (p1_inrange_r && p1_nz_r) begin
      if (held_lo && !held_hi) begin
        act_dec = ACT_RECOVER;
        tgt_dec = p1_hi_r;
        src_dec = p1_hi_r - FW'(1);
      end else if (!held_lo && held_hi) begin
        act_dec = ACT_RECOVER;
        tgt_dec = p1_hi_r - FW'(1);
        src_dec = p1_hi_r;
      end
    end
  end

  assign act_cur = p1_first_r ? act_dec : act_r;
  assign tgt_cur = p1_first_r ? tgt_dec : tgt_r;
  assign src_cur = p1_first_r ? src_dec : src_r;
  assign emit1   = p1_v_r && (act_cur != ACT_DROP) && (p1_pos_r < PW'(PAYLOAD_BYTES));
  assign held_we = advance && p1_v_r && p1_first_r && (act_dec != ACT_DROP);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= ACT_DROP;
      tgt_r <= '0;
      src_r <= '0;
    end else if (advance && p1_v_r && p1_first_r) begin
      act_r <= act_dec;
      tgt_r <= tgt_dec;
      src_r <= src_dec;
    end
  end

  // ---------------- stage 2 ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p2_v_r <= 1'b0;
    end else if (advance) begin
      p2_v_r <= emit1;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      p2_tgt_r  <= tgt_cur;
      p2_src_r  <= src_cur;
      p2_pos_r  <= p1_pos_r;
      p2_byte_r <= p1_byte_r;
      p2_last_r <= p1_last_r || (p1_pos_r == PW'(PAYLOAD_BYTES - 1));
      p2_rec_r  <= (act_cur == ACT_RECOVER);
    end
  end

  assign tgt_addr = AW'(p2_tgt_r) * AW'(PAYLOAD_BYTES) + AW'(p2_pos_r);
  assign src_addr = AW'(p2_src_r) * AW'(PAYLOAD_BYTES) + AW'(p2_pos_r);

  // ---------------- stage 3 ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p3_v_r  <= 1'b0;
      fwd_v_r <= 1'b0;
    end else if (advance) begin
      p3_v_r  <= p2_v_r;
      // word leaving now writes the address being read now
      fwd_v_r <= p3_v_r && (p3_addr_r == src_addr);
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      p3_addr_r <= tgt_addr;
      p3_seq_r  <= p2_tgt_r;
      p3_byte_r <= p2_byte_r;
      p3_last_r <= p2_last_r;
      p3_rec_r  <= p2_rec_r;
      fwd_d_r   <= out_data;
      rd_q_r    <= store_mem[src_addr];
    end
    if (advance && p3_v_r) begin
      store_mem[p3_addr_r] <= out_data;
    end
  end

  assign src_byte = fwd_v_r ? fwd_d_r : rd_q_r;
  assign out_data = p3_rec_r ? (src_byte ^ p3_byte_r) : p3_byte_r;

  assign out_word.valid     = p3_v_r;
  assign out_word.out_seq   = OUT_SEQ_W'(p3_seq_r);
  assign out_word.out_byte  = out_data;
  assign out_word.out_last  = p3_last_r;
  assign out_word.recovered = p3_rec_r;

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// Testbench for xor_fec_packet_recovery: directed and random packets, scoreboard check.
import xfec_pkg::*;

typedef struct packed {
  logic              is_parity;
  logic [SEQ_W-1:0]  seq;
  logic [BYTE_W-1:0] data;
  logic              last;
} in_word_t;

typedef struct packed {
  logic [OUT_SEQ_W-1:0] seq;
  logic [BYTE_W-1:0]    data;
  logic                 last;
  logic                 rec;
} out_word_t;

class recovery_scoreboard;
  bit          held_map [FRAMES_DEF];
  logic [7:0]  payload_mem [FRAMES_DEF*PAYLOAD_BYTES_DEF];
  // written prefix length per sequence, so rebuilds never read unwritten bytes
  int unsigned written_len [FRAMES_DEF];
  int unsigned rx_pos;
  act_t        pkt_act;
  int unsigned tgt_seq;
  int unsigned src_seq;
  out_word_t   expected_bytes [$];
  int unsigned mismatches;

  function new();
    rx_pos     = 0;
    pkt_act    = ACT_DROP;
    tgt_seq    = 0;
    src_seq    = 0;
    mismatches = 0;
  endfunction

  // Held sequence a parity packet would rebuild from, or -1 if it is dropped.
  function int rebuild_source(logic par, logic [SEQ_W-1:0] s);
    if (!par || s == 0 || s >= FRAMES_DEF) return -1;
    if (held_map[s-1] && !held_map[s]) return int'(s) - 1;
    if (!held_map[s-1] && held_map[s]) return int'(s);
    return -1;
  endfunction

  // Longest packet allowed to start with these fields; 0 means no limit.
  function int unsigned byte_budget(logic par, logic [SEQ_W-1:0] s);
    int src;
    src = rebuild_source(par, s);
    if (src < 0) return 0;
    return written_len[src];
  endfunction

  function void note_word(in_word_t w);
    int        src;
    out_word_t e;
    logic [7:0] ob;
    if (rx_pos == 0) begin
      pkt_act = ACT_DROP;
      if (!w.is_parity) begin
        if (w.seq < FRAMES_DEF && !held_map[w.seq]) begin
          held_map[w.seq] = 1'b1;
          tgt_seq = 32'(w.seq);
          pkt_act = ACT_FORWARD;
        end
      end else begin
        src = rebuild_source(1'b1, w.seq);
        if (src >= 0) begin
          src_seq = unsigned'(src);
          tgt_seq = (src == int'(w.seq)) ? 32'(w.seq) - 32'd1 : 32'(w.seq);
          held_map[tgt_seq] = 1'b1;
          pkt_act = ACT_RECOVER;
        end
      end
    end
    if (rx_pos < PAYLOAD_BYTES_DEF && pkt_act != ACT_DROP) begin
      ob = w.data;
      if (pkt_act == ACT_RECOVER)
        ob = payload_mem[src_seq*PAYLOAD_BYTES_DEF + rx_pos] ^ w.data;
      payload_mem[tgt_seq*PAYLOAD_BYTES_DEF + rx_pos] = ob;
      if (written_len[tgt_seq] < rx_pos + 1) written_len[tgt_seq] = rx_pos + 1;
      e.seq  = tgt_seq[OUT_SEQ_W-1:0];
      e.data = ob;
      e.last = w.last || (rx_pos == PAYLOAD_BYTES_DEF - 1);
      e.rec  = (pkt_act == ACT_RECOVER);
      expected_bytes.push_back(e);
    end
    if (w.last) rx_pos = 0;
    else if (rx_pos < PAYLOAD_BYTES_DEF) rx_pos++;
  endfunction

  function void check_word(out_word_t got);
    out_word_t e;
    if (expected_bytes.size() == 0) begin
      if (mismatches < 10)
        $display("unexpected word: seq %0d byte %02h last %0b rec %0b",
                 got.seq, got.data, got.last, got.rec);
      mismatches++;
      return;
    end
    e = expected_bytes.pop_front();
    if (got.seq !== e.seq || got.data !== e.data || got.last !== e.last ||
        got.rec !== e.rec) begin
      if (mismatches < 10)
        $display("mismatch: exp seq %0d byte %02h last %0b rec %0b, got %0d %02h %0b %0b",
                 e.seq, e.data, e.last, e.rec, got.seq, got.data, got.last, got.rec);
      mismatches++;
    end
  endfunction
endclass

module tb_top;
  localparam int unsigned ITEM_TARGET = 1550;
  localparam int unsigned PB          = PAYLOAD_BYTES_DEF;

  logic clk;
  logic rst_n;

  xfec_in_if  in_word ();
  xfec_out_if out_word ();

  xor_fec_packet_recovery i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_word  (in_word),
    .out_word (out_word)
  );

  recovery_scoreboard sb = new();

  int unsigned words_sent   = 0;
  int unsigned results_seen = 0;
  int unsigned send_burst   = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #(3_000_000);
    $display("TB_ERROR");
    $finish;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (send_burst > 0) begin
      send_burst--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 10) begin
      send_burst = $urandom_range(20, 120);
      return 0;
    end
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic int unsigned pick_len();
    int unsigned r;
    r = $urandom_range(0, 999);
    if (r < 5) return $urandom_range(PB - 1, PB + 12);
    if (r < 700) return $urandom_range(1, 8);
    return $urandom_range(9, 40);
  endfunction

  task automatic send_word(in_word_t w);
    int unsigned gap;
    @(negedge clk);
    in_word.valid     <= 1'b1;
    in_word.is_parity <= w.is_parity;
    in_word.seq       <= w.seq;
    in_word.data_byte <= w.data;
    in_word.last_byte <= w.last;
    do @(posedge clk); while (!in_word.ready);
    sb.note_word(w);
    words_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_word.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic send_packet(logic par, logic [SEQ_W-1:0] s, int unsigned len,
                             bit scramble);
    int unsigned lim;
    in_word_t    w;
    lim = sb.byte_budget(par, s);
    if (lim != 0 && lim < PB && len > lim) len = lim;
    for (int unsigned i = 0; i < len; i++) begin
      w.is_parity = par;
      w.seq       = s;
      // only the first word's tag and sequence count
      if (i > 0 && scramble) begin
        w.is_parity = 1'($urandom_range(0, 1));
        w.seq       = SEQ_W'($urandom());
      end
      w.data = 8'($urandom_range(0, 255));
      w.last = (i == len - 1);
      send_word(w);
    end
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_word.valid <= 1'b0;
    while (sb.expected_bytes.size() != 0) @(negedge clk);
  endtask

  // result sampling
  initial begin : result_mon
    out_word_t got;
    forever begin
      @(posedge clk);
      if (rst_n && out_word.valid && out_word.ready) begin
        got.seq  = out_word.out_seq;
        got.data = out_word.out_byte;
        got.last = out_word.out_last;
        got.rec  = out_word.recovered;
        sb.check_word(got);
        results_seen++;
      end
    end
  end

  // result-side backpressure
  initial begin : rx_ready_gen
    int unsigned stall;
    int unsigned calm;
    int unsigned r;
    bit          held_off;
    stall          = 0;
    calm           = 0;
    held_off       = 1'b0;
    out_word.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!held_off && results_seen >= 100) begin
        // long hold-off so the pipeline backs up into the input
        held_off = 1'b1;
        out_word.ready <= 1'b0;
        repeat (400) @(negedge clk);
      end else if (calm > 0) begin
        calm--;
        out_word.ready <= 1'b1;
      end else if (stall > 0) begin
        stall--;
        out_word.ready <= 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 10) calm = $urandom_range(20, 150);
        else if (r < 40) stall = $urandom_range(1, 3);
        else if (r < 43) stall = $urandom_range(10, 50);
        out_word.ready <= 1'b1;
      end
    end
  end

  initial begin : stim
    in_word_t          w;
    logic [SEQ_W-1:0]  s;
    int unsigned       r;
    int unsigned       len;
    bit                lo_first;
    bit                paused;
    rst_n             = 1'b0;
    in_word.valid     = 1'b0;
    in_word.is_parity = 1'b0;
    in_word.seq       = '0;
    in_word.data_byte = '0;
    in_word.last_byte = 1'b0;
    paused            = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // data for seq 0 carrying the byte extremes
    w = '{is_parity: 1'b0, seq: '0, data: 8'h00, last: 1'b0};
    send_word(w);
    w.data = 8'hFF;
    w.last = 1'b1;
    send_word(w);
    send_packet(1'b0, 0, 1, 1'b0);             // duplicate, dropped
    send_packet(1'b1, 0, 1, 1'b0);             // parity for seq zero, dropped
    send_packet(1'b1, 1, 2, 1'b0);             // rebuild seq 1 from seq 0
    send_packet(1'b1, 1, 1, 1'b0);             // both held, dropped
    send_packet(1'b0, 3, 1, 1'b0);
    send_packet(1'b1, 3, 1, 1'b0);             // rebuild lower seq 2 from seq 3
    send_packet(1'b1, 6, 1, 1'b0);             // neither held, dropped
    send_packet(1'b0, SEQ_W'(FRAMES_DEF - 1), 2, 1'b1);
    send_packet(1'b0, SEQ_W'(FRAMES_DEF), 1, 1'b0);    // out of range
    send_packet(1'b0, {SEQ_W{1'b1}}, 1, 1'b0);
    send_packet(1'b1, SEQ_W'(FRAMES_DEF), 1, 1'b0);
    send_packet(1'b1, {SEQ_W{1'b1}}, 1, 1'b0);
    send_packet(1'b0, 512, 3, 1'b1);
    send_packet(1'b1, 513, 3, 1'b1);
    wait_drained();

    // full-length data, then an overlong parity packet rebuilding its neighbor
    send_packet(1'b0, 700, PB, 1'b0);
    send_packet(1'b1, 701, PB + 5, 1'b0);

    while (words_sent < ITEM_TARGET) begin
      if (!paused && words_sent >= ITEM_TARGET / 2) begin
        paused = 1'b1;
        wait_drained();
      end
      s = SEQ_W'($urandom_range(1, FRAMES_DEF - 1));
      r = $urandom_range(0, 99);
      if (r < 45) begin
        // one of the covered pair arrives, sometimes the other one too, then its parity
        lo_first = 1'($urandom_range(0, 1));
        len = pick_len();
        send_packet(1'b0, lo_first ? s - 1 : s, len, $urandom_range(0, 4) == 0);
        if ($urandom_range(0, 4) == 0)
          send_packet(1'b0, lo_first ? s : s - 1, pick_len(), 1'b0);
        if ($urandom_range(0, 3) == 0) len = pick_len();
        else len = $urandom_range(1, len);
        send_packet(1'b1, s, len, $urandom_range(0, 4) == 0);
      end else if (r < 70) begin
        send_packet(1'b0, s, pick_len(), $urandom_range(0, 4) == 0);
      end else if (r < 80) begin
        send_packet(1'b0, SEQ_W'($urandom_range(0, FRAMES_DEF - 1)), pick_len(), 1'b0);
      end else if (r < 90) begin
        send_packet(1'b1, SEQ_W'($urandom_range(0, FRAMES_DEF - 1)), pick_len(),
                    $urandom_range(0, 4) == 0);
      end else begin
        send_packet(1'($urandom_range(0, 1)), SEQ_W'($urandom()), pick_len(), 1'b1);
      end
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (sb.mismatches == 0 && sb.expected_bytes.size() == 0) begin
      $display("TB_OK");
    end else begin
      if (sb.expected_bytes.size() != 0)
        $display("%0d expected words never arrived", sb.expected_bytes.size());
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
